[design/rws_pkg.sv]
package rws_pkg;

   localparam int FIT_W     = 17;
   localparam int BASE_W    = 16;
   localparam int RND_W     = 16;
   localparam int CMD_W     = 3;
   localparam int STAT_W    = 2;
   localparam int IDX_OUT_W = 8;
   localparam int TOT_W     = 9;

   localparam logic [FIT_W-1:0]  FIT_ONE    = 17'h10000;
   localparam logic [BASE_W-1:0] BASE_RESET = 16'd66;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_LOAD   = 3'd1,
      CMD_SELECT = 3'd2,
      CMD_PAIR   = 3'd3,
      CMD_BEST   = 3'd4
   } command_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2,
      STAT_FEW   = 2'd3
   } status_type;

   typedef struct packed {
      logic done;
      logic found;
   } scan_status_type;

endpackage

[design/rws_table.sv]
module rws_table #(
   parameter int DEPTH  = 256,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [ADDR_W-1:0]         wr_addr,
   input  logic [rws_pkg::FIT_W-1:0] wr_data,
   input  logic                      rd_en,
   input  logic [ADDR_W-1:0]         rd_addr,
   output logic [rws_pkg::FIT_W-1:0] rd_data
);
   import rws_pkg::*;

   logic [FIT_W-1:0] mem_ff [DEPTH];
   logic [FIT_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/rws_scan.sv]
module rws_scan #(
   parameter int CNT_W  = 9,
   parameter int IDX_W  = 8,
   parameter int SUM_W  = 25,
   parameter int PICK_W = 42
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        go,
   input  logic [PICK_W-1:0]           pick,
   input  logic [CNT_W-1:0]            count,
   input  logic [rws_pkg::BASE_W-1:0]  base,
   input  logic [rws_pkg::FIT_W-1:0]   rd_data,
   output logic                        rd_en,
   output logic [IDX_W-1:0]            rd_addr,
   output rws_pkg::scan_status_type    status,
   output logic [IDX_W-1:0]            hit_index,
   output logic [SUM_W-1:0]            bin_low,
   output logic [rws_pkg::FIT_W:0]     bin_weight
);
   import rws_pkg::*;

   logic               running_ff;
   logic [CNT_W-1:0]   addr_ff;
   logic               pend_ff;
   logic [IDX_W-1:0]   pend_idx_ff;
   logic [SUM_W-1:0]   acc_ff;
   logic [FIT_W:0]     w0_ff;

   logic [FIT_W:0]     entry_w;
   logic [SUM_W-1:0]   acc_in;
   logic               hit;
   logic               last;
   logic               stop;

   assign entry_w = {1'b0, rd_data} + {2'b00, base};
   assign acc_in  = acc_ff + SUM_W'(entry_w);
   assign hit     = pend_ff && (PICK_W'(acc_in) > pick);
   assign last    = pend_ff && (CNT_W'(pend_idx_ff) == (count - CNT_W'(1)));
   assign stop    = hit || last;

   assign rd_en   = running_ff && (addr_ff < count);
   assign rd_addr = addr_ff[IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else if (go) begin
         running_ff <= 1'b1;
         pend_ff    <= 1'b0;
         addr_ff    <= '0;
         acc_ff     <= '0;
      end else if (stop) begin
         running_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         pend_ff <= rd_en;
         if (rd_en) begin
            addr_ff     <= addr_ff + CNT_W'(1);
            pend_idx_ff <= addr_ff[IDX_W-1:0];
         end
         if (pend_ff) begin
            acc_ff <= acc_in;
            if (pend_idx_ff == '0) begin
               w0_ff <= entry_w;
            end
         end
      end
   end

   // a miss falls back to the bin of entry zero
   assign status.done  = stop;
   assign status.found = hit;
   assign hit_index    = pend_idx_ff;
   assign bin_low      = hit ? acc_ff : '0;
   assign bin_weight   = (hit || (pend_idx_ff == '0)) ? entry_w : w0_ff;

endmodule

[design/roulette_wheel_selector.sv]
// Fitness-proportionate selector. Issue a command with start while busy is low; each command
// yields exactly one result beat on the rsp_ ports, marked by rsp_strobe for a single cycle,
// and the receiver cannot stall it, so it must be taken when shown. Clear, load, report
// fittest, errors and unknown codes never raise busy: the beat appears the cycle after
// acceptance. Select one and select pair keep busy high while they scan the fitness memory,
// one entry per cycle through its single read port, until the pick is passed or the loaded
// count is reached; select pair scans twice, with range, multiply and adjust states between.
// The result beat appears in the same cycle that busy falls.
// There is no clearing pass after reset; stale entries above the loaded count are never read.
module roulette_wheel_selector #(
   parameter int MAX_POPULATION = 256,
   parameter int FRACTION_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [rws_pkg::CMD_W-1:0]     req_command,
   input  logic [rws_pkg::FIT_W-1:0]     req_fitness,
   input  logic [rws_pkg::RND_W-1:0]     req_random_first,
   input  logic [rws_pkg::RND_W-1:0]     req_random_second,
   output logic                          rsp_strobe,
   output logic [rws_pkg::STAT_W-1:0]    rsp_status,
   output logic [rws_pkg::IDX_OUT_W-1:0] rsp_first_index,
   output logic [rws_pkg::IDX_OUT_W-1:0] rsp_second_index,
   output logic [rws_pkg::FIT_W-1:0]     rsp_best_fitness,
   output logic [rws_pkg::TOT_W-1:0]     rsp_entry_total,
   input  logic                          csr_write_enable,
   input  logic [rws_pkg::BASE_W-1:0]    csr_write_data
);
   import rws_pkg::*;

   localparam int IDX_W  = $clog2(MAX_POPULATION);
   localparam int CNT_W  = $clog2(MAX_POPULATION + 1);
   localparam int SUM_W  = FIT_W + IDX_W;
   localparam int PROD_W = SUM_W + RND_W;
   localparam int PICK_W = PROD_W + 1;
   localparam int W_W    = FIT_W + 1;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_GO1   = 8'b0000_0010,
      ST_SCAN1 = 8'b0000_0100,
      ST_RANGE = 8'b0000_1000,
      ST_MUL2  = 8'b0001_0000,
      ST_ADJ   = 8'b0010_0000,
      ST_GO2   = 8'b0100_0000,
      ST_SCAN2 = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [IDX_W-1:0]  best_idx_ff, best_idx_in;
   logic [FIT_W-1:0]  best_val_ff, best_val_in;
   logic [BASE_W-1:0] base_ff;
   logic [PICK_W-1:0] pick_ff, pick_in;
   logic [RND_W-1:0]  rnd2_ff, rnd2_in;
   logic              pair_ff, pair_in;
   logic [IDX_W-1:0]  first_ff, first_in;
   logic [SUM_W-1:0]  low_ff, low_in;
   logic [W_W-1:0]    wt_ff, wt_in;
   logic [SUM_W-1:0]  range_ff, range_in;
   logic [PICK_W-1:0] raw_ff, raw_in;

   logic              rsp_strobe_ff, rsp_strobe_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]  rsp_first_ff, rsp_first_in;
   logic [IDX_W-1:0]  rsp_second_ff, rsp_second_in;
   logic [FIT_W-1:0]  rsp_best_ff, rsp_best_in;
   logic [CNT_W-1:0]  rsp_total_ff, rsp_total_in;

   logic              accept;
   logic [FIT_W-1:0]  fit_sat;
   logic [RND_W-1:0]  mul_a;
   logic [SUM_W-1:0]  mul_b;
   logic [PROD_W-1:0] product;
   logic              wr_en;
   logic              scan_go;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [FIT_W-1:0]  rd_data;
   scan_status_type   scan_st;
   logic [IDX_W-1:0]  hit_index;
   logic [SUM_W-1:0]  bin_low;
   logic [W_W-1:0]    bin_weight;
   logic [IDX_W-1:0]  first_sel;
   logic [IDX_W-1:0]  second_sel;

   logic [IDX_W+IDX_OUT_W-1:0] first_wide;
   logic [IDX_W+IDX_OUT_W-1:0] second_wide;
   logic [CNT_W+TOT_W-1:0]     total_wide;

   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign fit_sat = (req_fitness > FIT_ONE) ? FIT_ONE : req_fitness;
   assign scan_go = (state_ff == ST_GO1) || (state_ff == ST_GO2);

   // share one multiplier between the two draws
   assign mul_a   = (state_ff == ST_IDLE) ? req_random_first : rnd2_ff;
   assign mul_b   = (state_ff == ST_IDLE) ? sum_ff : range_ff;
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign first_sel  = scan_st.found ? hit_index : '0;
   assign second_sel = (!scan_st.found || (hit_index == first_ff)) ?
                       ((first_ff == '0) ? IDX_W'(1) : '0) : hit_index;

   rws_table #(
      .DEPTH  (MAX_POPULATION),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[IDX_W-1:0]),
      .wr_data (fit_sat),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rws_scan #(
      .CNT_W  (CNT_W),
      .IDX_W  (IDX_W),
      .SUM_W  (SUM_W),
      .PICK_W (PICK_W)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .go         (scan_go),
      .pick       (pick_ff),
      .count      (count_ff),
      .base       (base_ff),
      .rd_data    (rd_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .status     (scan_st),
      .hit_index  (hit_index),
      .bin_low    (bin_low),
      .bin_weight (bin_weight)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      best_idx_in   = best_idx_ff;
      best_val_in   = best_val_ff;
      pick_in       = pick_ff;
      rnd2_in       = rnd2_ff;
      pair_in       = pair_ff;
      first_in      = first_ff;
      low_in        = low_ff;
      wt_in         = wt_ff;
      range_in      = range_ff;
      raw_in        = raw_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = STAT_OK;
      rsp_first_in  = '0;
      rsp_second_in = '0;
      rsp_best_in   = best_val_ff;
      rsp_total_in  = count_ff;
      wr_en         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_strobe_in = 1'b1;
               unique case (req_command)
                  CMD_CLEAR: begin
                     count_in     = '0;
                     sum_in       = '0;
                     best_idx_in  = '0;
                     best_val_in  = '0;
                     rsp_best_in  = '0;
                     rsp_total_in = '0;
                  end
                  CMD_LOAD: begin
                     if (count_ff == CNT_W'(MAX_POPULATION)) begin
                        rsp_status_in = STAT_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        sum_in   = sum_ff + SUM_W'(fit_sat) + SUM_W'(base_ff);
                        count_in = count_ff + CNT_W'(1);
                        if ((count_ff == '0) || (fit_sat > best_val_ff)) begin
                           best_val_in = fit_sat;
                           best_idx_in = count_ff[IDX_W-1:0];
                        end
                        rsp_best_in  = best_val_in;
                        rsp_total_in = count_in;
                     end
                  end
                  CMD_SELECT: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        pick_in       = PICK_W'(product >> FRACTION_BITS);
                        pair_in       = 1'b0;
                        state_in      = ST_GO1;
                     end
                  end
                  CMD_PAIR: begin
                     if (count_ff < CNT_W'(2)) begin
                        rsp_status_in = STAT_FEW;
                     end else begin
                        rsp_strobe_in = 1'b0;
                        pick_in       = PICK_W'(product >> FRACTION_BITS);
                        pair_in       = 1'b1;
                        rnd2_in       = req_random_second;
                        state_in      = ST_GO1;
                     end
                  end
                  CMD_BEST: begin
                     if (count_ff == '0) begin
                        rsp_status_in = STAT_EMPTY;
                     end else begin
                        rsp_first_in = best_idx_ff;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_GO1: begin
            state_in = ST_SCAN1;
         end
         ST_SCAN1: begin
            if (scan_st.done) begin
               if (!pair_ff) begin
                  rsp_strobe_in = 1'b1;
                  rsp_first_in  = first_sel;
                  state_in      = ST_IDLE;
               end else begin
                  first_in = first_sel;
                  low_in   = bin_low;
                  wt_in    = bin_weight;
                  state_in = ST_RANGE;
               end
            end
         end
         ST_RANGE: begin
            range_in = (sum_ff > SUM_W'(wt_ff)) ? (sum_ff - SUM_W'(wt_ff)) : '0;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            raw_in   = PICK_W'(product >> FRACTION_BITS);
            state_in = ST_ADJ;
         end
         ST_ADJ: begin
            // skip past the first parent's bin
            pick_in  = (raw_ff >= PICK_W'(low_ff)) ? (raw_ff + PICK_W'(wt_ff)) : raw_ff;
            state_in = ST_GO2;
         end
         ST_GO2: begin
            state_in = ST_SCAN2;
         end
         ST_SCAN2: begin
            if (scan_st.done) begin
               rsp_strobe_in = 1'b1;
               rsp_first_in  = first_ff;
               rsp_second_in = second_sel;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         sum_ff        <= '0;
         best_idx_ff   <= '0;
         best_val_ff   <= '0;
         base_ff       <= BASE_RESET;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sum_ff        <= sum_in;
         best_idx_ff   <= best_idx_in;
         best_val_ff   <= best_val_in;
         rsp_strobe_ff <= rsp_strobe_in;
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      pick_ff       <= pick_in;
      rnd2_ff       <= rnd2_in;
      pair_ff       <= pair_in;
      first_ff      <= first_in;
      low_ff        <= low_in;
      wt_ff         <= wt_in;
      range_ff      <= range_in;
      raw_ff        <= raw_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_best_ff   <= rsp_best_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign first_wide  = {{IDX_OUT_W{1'b0}}, rsp_first_ff};
   assign second_wide = {{IDX_OUT_W{1'b0}}, rsp_second_ff};
   assign total_wide  = {{TOT_W{1'b0}}, rsp_total_ff};

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_first_index  = first_wide[IDX_OUT_W-1:0];
   assign rsp_second_index = second_wide[IDX_OUT_W-1:0];
   assign rsp_best_fitness = rsp_best_ff;
   assign rsp_entry_total  = total_wide[TOT_W-1:0];

   a_pair_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN2 && scan_st.done) |-> (second_sel != first_ff))
      else $error("pair beat with equal parents");

   a_full_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_LOAD && count_ff == CNT_W'(MAX_POPULATION))
      |=> ($stable(count_ff) && $stable(sum_ff)))
      else $error("load into full table changed state");

   a_error_no_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != STAT_OK) |-> (rsp_first_index == '0 && rsp_second_index == '0))
      else $error("error beat carries an index");

   a_done_in_scan: assert property (@(posedge clock) disable iff (reset)
      scan_st.done |-> (state_ff == ST_SCAN1 || state_ff == ST_SCAN2))
      else $error("scan finished outside a scan state");

endmodule

[verif/roulette_wheel_selector_test.sv]
`timescale 1ns / 1ps

module roulette_wheel_selector_test;
   import rws_pkg::*;

   localparam int POPULATION   = 256;
   localparam int FRACTION     = 16;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 120;
   localparam int FULL_PHASE   = 2;
   localparam int DRAIN_CYCLES = 600;
   localparam int CYCLE_LIMIT  = 4000000;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [FIT_W-1:0] fitness;
      logic [RND_W-1:0] random_first;
      logic [RND_W-1:0] random_second;
   } wheel_request_type;

   typedef struct packed {
      status_type           status;
      logic [IDX_OUT_W-1:0] first_index;
      logic [IDX_OUT_W-1:0] second_index;
      logic [FIT_W-1:0]     best_fitness;
      logic [TOT_W-1:0]     entry_total;
   } wheel_outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   wheel_request_type    shown = '0;
   logic                 rsp_strobe;
   logic [STAT_W-1:0]    rsp_status;
   logic [IDX_OUT_W-1:0] rsp_first_index;
   logic [IDX_OUT_W-1:0] rsp_second_index;
   logic [FIT_W-1:0]     rsp_best_fitness;
   logic [TOT_W-1:0]     rsp_entry_total;
   logic                 csr_write_enable = 1'b0;
   logic [BASE_W-1:0]    csr_write_data = '0;

   wheel_request_type pending_requests[$];
   wheel_outcome_type expected_outcomes[$];
   wheel_outcome_type want;
   int unsigned  beats_queued = 0;
   int unsigned  beats_back = 0;
   int unsigned  commands_counted = 0;
   int unsigned  burst_left = 0;
   int unsigned  gap_left = 0;
   int unsigned  cycle_count = 0;
   logic         took = 1'b0;
   bit           mismatch_seen = 1'b0;

   logic [FIT_W-1:0]  wheel_fitness [POPULATION];
   logic [TOT_W-1:0]  wheel_count = '0;
   logic [24:0]       wheel_total = '0;
   logic [7:0]        fittest_entry = '0;
   logic [FIT_W-1:0]  fittest_value = '0;
   logic [BASE_W-1:0] wheel_base = BASE_RESET;

   roulette_wheel_selector #(
      .MAX_POPULATION(POPULATION),
      .FRACTION_BITS(FRACTION)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_command(shown.command),
      .req_fitness(shown.fitness),
      .req_random_first(shown.random_first),
      .req_random_second(shown.random_second),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_first_index(rsp_first_index),
      .rsp_second_index(rsp_second_index),
      .rsp_best_fitness(rsp_best_fitness),
      .rsp_entry_total(rsp_entry_total),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned scale_fraction(input logic [RND_W-1:0] frac,
                                                      input longint unsigned span);
      longint unsigned wide;
      wide = 64'(frac);
      return (wide * span) >> FRACTION;
   endfunction

   // first slot whose running weight passes the pick, with its bin bounds
   function automatic logic find_slot(input longint unsigned pick, output int unsigned slot,
                                      output longint unsigned lo, output longint unsigned hi);
      longint unsigned acc;
      longint unsigned weight;
      acc = 0;
      slot = 0;
      lo = 0;
      hi = 0;
      for (int unsigned i = 0; i < wheel_count; i++) begin
         weight = 64'(wheel_fitness[i]);
         weight += 64'(wheel_base);
         if (acc + weight > pick) begin
            slot = i;
            lo = acc;
            hi = acc + weight;
            return 1'b1;
         end
         acc += weight;
      end
      return 1'b0;
   endfunction

   function automatic wheel_outcome_type spin_wheel(input wheel_request_type req);
      wheel_outcome_type res;
      logic [FIT_W-1:0] fit;
      longint unsigned lo, hi, lo2, hi2, span, reach, pick2;
      int unsigned     slot, slot2;
      logic            hit;
      res = '0;
      res.status = STAT_OK;
      case (req.command)
         CMD_CLEAR: begin
            wheel_count = '0;
            wheel_total = '0;
            fittest_entry = '0;
            fittest_value = '0;
         end
         CMD_LOAD: begin
            if (wheel_count >= POPULATION) begin
               res.status = STAT_FULL;
            end else begin
               fit = (req.fitness > FIT_ONE) ? FIT_ONE : req.fitness;
               wheel_fitness[wheel_count] = fit;
               wheel_total = wheel_total + 25'(fit) + 25'(wheel_base);
               if (wheel_count == 0 || fit > fittest_value) begin
                  fittest_value = fit;
                  fittest_entry = wheel_count[7:0];
               end
               wheel_count = wheel_count + TOT_W'(1);
            end
         end
         CMD_SELECT: begin
            if (wheel_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               hit = find_slot(scale_fraction(req.random_first, 64'(wheel_total)), slot, lo, hi);
               res.first_index = hit ? slot[7:0] : '0;
            end
         end
         CMD_PAIR: begin
            if (wheel_count < 2) begin
               res.status = STAT_FEW;
            end else begin
               hit = find_slot(scale_fraction(req.random_first, 64'(wheel_total)), slot, lo, hi);
               if (!hit) begin
                  slot = 0;
                  lo = 0;
                  hi = 64'(wheel_fitness[0]);
                  hi += 64'(wheel_base);
               end
               span = hi - lo;
               reach = (64'(wheel_total) > span) ? 64'(wheel_total) - span : 0;
               pick2 = scale_fraction(req.random_second, reach);
               if (pick2 >= lo) begin
                  pick2 += span;
               end
               hit = find_slot(pick2, slot2, lo2, hi2);
               res.first_index = slot[7:0];
               if (!hit || slot2 == slot) begin
                  res.second_index = (slot == 0) ? 8'd1 : 8'd0;
               end else begin
                  res.second_index = slot2[7:0];
               end
            end
         end
         CMD_BEST: begin
            if (wheel_count == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.first_index = fittest_entry;
            end
         end
         default: begin
         end
      endcase
      res.best_fitness = fittest_value;
      res.entry_total = wheel_count;
      return res;
   endfunction

   function automatic void check_field(input string name, input logic [FIT_W-1:0] expected_value,
                                       input logic [FIT_W-1:0] actual_value);
      if (actual_value !== expected_value) begin
         $error("%s expected %0d actual %0d", name, expected_value, actual_value);
         mismatch_seen = 1'b1;
      end
   endfunction

   function automatic logic [FIT_W-1:0] random_fitness();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return FIT_ONE;
         2: return FIT_W'($urandom);
         default: return FIT_W'($urandom_range(0, FIT_ONE));
      endcase
   endfunction

   function automatic logic [RND_W-1:0] random_fraction();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return RND_W'($urandom);
      endcase
   endfunction

   task automatic queue_request(input logic [CMD_W-1:0] cmd, input logic [FIT_W-1:0] fit,
                                input logic [RND_W-1:0] r1, input logic [RND_W-1:0] r2);
      wheel_request_type item;
      item = '{cmd, fit, r1, r2};
      pending_requests.insert(pending_requests.size(), item);
      beats_queued++;
      if (cmd <= CMD_BEST) begin
         commands_counted++;
      end
   endtask

   task automatic wait_idle();
      do begin
         @(negedge clock);
      end while (beats_back != beats_queued || busy !== 1'b0);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !took) begin
         // hold the beat until it is taken
      end else if (gap_left != 0) begin
         start <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_requests.size() != 0) begin
         shown <= pending_requests.pop_front();
         start <= 1'b1;
         if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end else begin
            burst_left <= burst_left - 1;
         end
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         took <= 1'b0;
      end else begin
         if (rsp_strobe !== 1'b0) begin
            beats_back++;
            if (expected_outcomes.size() == 0) begin
               $error("result beat with no command outstanding");
               mismatch_seen = 1'b1;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("status", FIT_W'(want.status), FIT_W'(rsp_status));
               check_field("first_index", FIT_W'(want.first_index), FIT_W'(rsp_first_index));
               check_field("second_index", FIT_W'(want.second_index),
                           FIT_W'(rsp_second_index));
               check_field("best_fitness", want.best_fitness, rsp_best_fitness);
               check_field("entry_total", FIT_W'(want.entry_total), FIT_W'(rsp_entry_total));
            end
         end
         took <= start && busy === 1'b0;
         if (start && busy === 1'b0) begin
            expected_outcomes.insert(expected_outcomes.size(), spin_wheel(shown));
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      logic [BASE_W-1:0] base;
      int unsigned       quota;
      int unsigned       loads;
      int unsigned       ops;
      int unsigned       roll;
      bit                opening;
      bit                zero_run;

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // empty and single-entry errors, saturation, extreme fractions, unknown codes
      queue_request(CMD_SELECT, random_fitness(), random_fraction(), random_fraction());
      queue_request(CMD_BEST, random_fitness(), random_fraction(), random_fraction());
      queue_request(CMD_PAIR, random_fitness(), random_fraction(), random_fraction());
      queue_request({CMD_W{1'b1}}, '1, '1, '1);
      queue_request(CMD_LOAD, '0, '0, '0);
      queue_request(CMD_PAIR, random_fitness(), random_fraction(), random_fraction());
      queue_request(CMD_LOAD, '1, random_fraction(), random_fraction());
      queue_request(CMD_LOAD, FIT_ONE, random_fraction(), random_fraction());
      queue_request(CMD_LOAD, 17'd1, random_fraction(), random_fraction());
      queue_request(CMD_SELECT, random_fitness(), '0, random_fraction());
      queue_request(CMD_SELECT, random_fitness(), '1, random_fraction());
      queue_request(CMD_PAIR, random_fitness(), '0, '0);
      queue_request(CMD_PAIR, random_fitness(), '1, '1);
      queue_request(CMD_PAIR, random_fitness(), '1, '0);
      queue_request(CMD_PAIR, random_fitness(), '0, '1);
      queue_request(CMD_BEST, random_fitness(), random_fraction(), random_fraction());
      queue_request(CMD_W'(int'(CMD_BEST) + 1), random_fitness(), random_fraction(),
                    random_fraction());
      queue_request(CMD_CLEAR, random_fitness(), random_fraction(), random_fraction());
      queue_request(CMD_BEST, random_fitness(), random_fraction(), random_fraction());

      for (int phase = 1; phase <= PHASES; phase++) begin
         wait_idle();
         case (phase)
            1, 4: base = '0;
            2: base = '1;
            PHASES: base = BASE_RESET;
            default: base = BASE_W'($urandom);
         endcase
         csr_write_data <= base;
         csr_write_enable <= 1'b1;
         wheel_base = base;
         @(negedge clock);
         csr_write_enable <= 1'b0;

         quota = commands_counted + PHASE_ITEMS;
         opening = 1'b1;
         while (commands_counted < quota) begin
            // keep the old table at a phase opening, but for the full-table phase, so stale weights get exercised
            if ((opening && phase == FULL_PHASE) || (!opening && $urandom_range(0, 4) != 0)) begin
               queue_request(CMD_CLEAR, random_fitness(), random_fraction(), random_fraction());
            end
            zero_run = (base == 0) && ($urandom_range(0, 2) == 0);
            if (opening && phase == FULL_PHASE) begin
               loads = POPULATION + $urandom_range(1, 3);
            end else begin
               loads = $urandom_range(0, ($urandom_range(0, 5) == 0) ? 48 : 12);
            end
            for (int n = 0; n < loads; n++) begin
               queue_request(CMD_LOAD, zero_run ? '0 : random_fitness(), random_fraction(),
                             random_fraction());
            end
            ops = $urandom_range(2, 12);
            for (int n = 0; n < ops; n++) begin
               roll = $urandom_range(0, 19);
               if (roll < 7) begin
                  queue_request(CMD_SELECT, random_fitness(), random_fraction(),
                                random_fraction());
               end else if (roll < 14) begin
                  queue_request(CMD_PAIR, random_fitness(), random_fraction(),
                                random_fraction());
               end else if (roll < 16) begin
                  queue_request(CMD_BEST, random_fitness(), random_fraction(),
                                random_fraction());
               end else if (roll < 17) begin
                  queue_request(CMD_LOAD, random_fitness(), random_fraction(),
                                random_fraction());
               end else if (roll < 18) begin
                  queue_request(CMD_CLEAR, random_fitness(), random_fraction(),
                                random_fraction());
               end else begin
                  queue_request(CMD_W'($urandom_range(int'(CMD_BEST) + 1, (1 << CMD_W) - 1)),
                                random_fitness(), random_fraction(), random_fraction());
               end
            end
            opening = 1'b0;
         end
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_outcomes.size() != 0) begin
         $error("%0d result beats never arrived", expected_outcomes.size());
      end
      if (mismatch_seen || expected_outcomes.size() != 0) begin
         $display("status: fail");
      end else begin
         $display("status: pass");
      end
      $finish;
   end

endmodule

[sim.f]
design/rws_pkg.sv
design/rws_table.sv
design/rws_scan.sv
design/roulette_wheel_selector.sv
verif/roulette_wheel_selector_test.sv
